// ===== src/b64e_pkg.sv =====
// Shared types, constants and the alphabet function of the base64 stream encoder.
// No dependencies; every module of the block imports this package.
package b64e_pkg;

  localparam int unsigned SymW  = 6;
  localparam int unsigned CharW = 8;
  localparam int unsigned MaxChars = 4;

  // Register indexes on the configuration port.
  localparam logic [1:0] CfgSym62 = 2'd0;
  localparam logic [1:0] CfgSym63 = 2'd1;
  localparam logic [1:0] CfgPad   = 2'd2;

  localparam logic [CharW-1:0] Sym62Reset = 8'd43;  // '+'
  localparam logic [CharW-1:0] Sym63Reset = 8'd47;  // '/'
  localparam logic [CharW-1:0] PadReset   = 8'd61;  // '='

  // One request's worth of output characters, built by the front end.
  typedef struct packed {
    logic [MaxChars-1:0][SymW-1:0] sym;
    logic [MaxChars-1:0]           pad;
    logic [1:0]                    last;  // index of the final character
  } job_t;

  typedef struct packed {
    logic [CharW-1:0] sym62;
    logic [CharW-1:0] sym63;
    logic [CharW-1:0] pad;
  } cfg_t;

  function automatic logic [CharW-1:0] map_symbol(logic [SymW-1:0] s, cfg_t cfg);
    logic [CharW-1:0] ch;
    if (s < 6'd26)       ch = 8'd65 + {2'b00, s};
    else if (s < 6'd52)  ch = 8'd71 + {2'b00, s};   // 'a' - 26
    else if (s < 6'd62)  ch = {2'b00, s} - 8'd4;    // '0' - 52
    else if (s == 6'd62) ch = cfg.sym62;
    else                 ch = cfg.sym63;
    return ch;
  endfunction

endpackage

// ===== src/b64e_front.sv =====
// Front end: takes bytes, tracks the position in the 3-byte group and the
// leftover bits, and builds a character job for the queue. Uses b64e_pkg.
module b64e_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          in_byte_i,
  input  logic                in_eom_i,
  input  logic                q_full_i,
  output logic                in_ready_o,
  output logic                push_o,
  output b64e_pkg::job_t      job_o
);
  import b64e_pkg::*;

  logic [1:0] phase_q, phase_d;
  logic [3:0] carry_q, carry_d;
  logic       take;

  assign in_ready_o = !q_full_i;
  assign take       = in_valid_i && !q_full_i;
  assign push_o     = take;

  always_comb begin
    job_o   = '0;
    phase_d = phase_q;
    carry_d = carry_q;
    case (phase_q)
      2'd1: begin
        job_o.sym[0] = {carry_q[1:0], in_byte_i[7:4]};
        job_o.sym[1] = {in_byte_i[3:0], 2'b00};
        job_o.pad[2] = 1'b1;
        job_o.last   = in_eom_i ? 2'd2 : 2'd0;
        phase_d      = 2'd2;
        carry_d      = in_byte_i[3:0];
      end
      2'd2: begin
        job_o.sym[0] = {carry_q, in_byte_i[7:6]};
        job_o.sym[1] = in_byte_i[5:0];
        job_o.last   = 2'd1;
        phase_d      = 2'd0;
        carry_d      = 4'd0;
      end
      default: begin
        // phase 0, and the unused code treated alike
        job_o.sym[0] = in_byte_i[7:2];
        job_o.sym[1] = {in_byte_i[1:0], 4'b0000};
        job_o.pad[2] = 1'b1;
        job_o.pad[3] = 1'b1;
        job_o.last   = in_eom_i ? 2'd3 : 2'd0;
        phase_d      = 2'd1;
        carry_d      = {2'b00, in_byte_i[1:0]};
      end
    endcase
    if (in_eom_i) begin
      phase_d = 2'd0;
      carry_d = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      carry_q <= 4'd0;
    end else if (take) begin
      phase_q <= phase_d;
      carry_q <= carry_d;
    end
  end

endmodule

// ===== src/b64e_queue.sv =====
// Two-entry job queue between front end and back end.
// Uses b64e_pkg for the job type.
module b64e_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b64e_pkg::job_t push_data_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output b64e_pkg::job_t head_o
);
  import b64e_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== src/b64e_back.sv =====
// Back end: walks the head job one character a cycle unless the output stalls,
// maps symbols through the alphabet and drives the output register. Uses b64e_pkg.
module b64e_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  b64e_pkg::cfg_t    cfg_i,
  input  logic              head_valid_i,
  input  b64e_pkg::job_t    head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_char_o,
  output logic              out_last_o
);
  import b64e_pkg::*;

  logic [1:0]       pos_q, pos_d;
  logic             out_valid_q, out_valid_d;
  logic [CharW-1:0] out_char_q, out_char_d;
  logic             out_last_q, out_last_d;
  logic             load;

  assign load  = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && (pos_q == head_i.last);

  always_comb begin
    pos_d       = pos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_char_d  = head_i.pad[pos_q] ? cfg_i.pad : map_symbol(head_i.sym[pos_q], cfg_i);
    out_last_d  = (pos_q == head_i.last);
    if (load) begin
      out_valid_d = 1'b1;
      pos_d       = pop_o ? 2'd0 : pos_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_char_q <= out_char_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  a_mid_job_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q != 2'd0) |-> head_valid_i)
    else $error("character position advanced without a job at the queue head");

  a_pos_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> (pos_q <= head_i.last))
    else $error("character position beyond the job's final character");

  a_last_marks_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (out_valid_q && out_last_q))
    else $error("final character of a job not flagged as last");

  a_pad_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && head_i.pad[pos_q]) |=> (out_char_q == $past(cfg_i.pad)))
    else $error("pad slot did not emit the pad character");

endmodule

// ===== src/base64_stream_encoder.sv =====
// Base64 (RFC 4648) stream encoder, top level: config registers, front end,
// job queue and back end. Depends on b64e_pkg, b64e_front, b64e_queue, b64e_back.
//
// Bytes enter on the s_axis side, one per cycle while the two-entry job queue
// has room; each byte becomes one to four characters on the m_axis side, and
// the back end sends one character per cycle while the output side takes it.
// A byte carrying tlast also flushes the leftover bits and adds up to two
// pads. The single output character register sets the rate. tlast on the
// output marks the last character caused by each input byte. Symbol 62,
// symbol 63 and the pad character come from configuration registers 0, 1
// and 2 (reset '+', '/', '='); write them only while the block is idle.
// Index 3 is ignored.
module base64_stream_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // end_of_message
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] encoded_char
  output logic       m_axis_tlast,   // final_char
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  import b64e_pkg::*;

  cfg_t cfg_q;
  job_t push_job, head_job;
  logic push, pop, q_full, q_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sym62 <= Sym62Reset;
      cfg_q.sym63 <= Sym63Reset;
      cfg_q.pad   <= PadReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgSym62: cfg_q.sym62 <= cfg_data_i;
        CfgSym63: cfg_q.sym63 <= cfg_data_i;
        CfgPad:   cfg_q.pad   <= cfg_data_i;
        default:  ;  // drop writes to unused index
      endcase
    end
  end

  b64e_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .in_eom_i   (s_axis_tlast),
    .q_full_i   (q_full),
    .in_ready_o (s_axis_tready),
    .push_o     (push),
    .job_o      (push_job)
  );

  b64e_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (head_job)
  );

  b64e_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (q_valid),
    .head_i       (head_job),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_char_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule
